/* sv/twqo_pkg.sv */
// Package for the task wait queue ordering block.
// Holds field widths, command, mode and status codes, the controller state
// type and the control word handed to every queue cell. No dependencies.
package twqo_pkg;

    localparam int TASK_BITS     = 6;
    localparam int CODE_BITS     = 4;
    localparam int STATUS_BITS   = 3;
    localparam int CMD_BITS      = 2;
    localparam int MODE_BITS     = 2;
    localparam int PRIO_IN_BITS  = 16;

    localparam logic [CMD_BITS-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_BITS-1:0] CMD_REMOVE = 2'd1;
    localparam logic [CMD_BITS-1:0] CMD_FLUSH  = 2'd2;

    localparam logic [MODE_BITS-1:0] MODE_PRIO = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_FIFO = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_LIFO = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_BAD  = 2'd3;

    localparam logic [STATUS_BITS-1:0] STAT_OK        = 3'd0;
    localparam logic [STATUS_BITS-1:0] STAT_FULL      = 3'd1;
    localparam logic [STATUS_BITS-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_BITS-1:0] STAT_EMPTY     = 3'd3;
    localparam logic [STATUS_BITS-1:0] STAT_BAD_MODE  = 3'd4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_FLUSH
    } state_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_INSERT,
        CELL_REMOVE,
        CELL_SHIFT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     prio_mode;
        logic     lifo_mode;
    } cell_ctrl_t;

endpackage

/* sv/twqo_cell.sv */
// One slot of the wait queue: a task id and its priority.
// Depends on twqo_pkg for the control word and field widths.
module twqo_cell #(
    parameter int PRIO_BITS = 16
) (
    input  logic                        clk,
    input  twqo_pkg::cell_ctrl_t        ctrl,
    input  logic                        occupied,
    input  logic                        at_tail,
    input  logic                        is_head,
    input  logic [twqo_pkg::TASK_BITS-1:0] new_task,
    input  logic [PRIO_BITS-1:0]        new_prio,
    input  logic [twqo_pkg::TASK_BITS-1:0] left_task,
    input  logic [PRIO_BITS-1:0]        left_prio,
    input  logic [twqo_pkg::TASK_BITS-1:0] right_task,
    input  logic [PRIO_BITS-1:0]        right_prio,
    input  logic                        chain_in,
    output logic                        chain_out,
    output logic [twqo_pkg::TASK_BITS-1:0] task_id,
    output logic [PRIO_BITS-1:0]        prio
);
    import twqo_pkg::*;

    logic [TASK_BITS-1:0] task_reg, task_next;
    logic [PRIO_BITS-1:0] prio_reg, prio_next;
    logic                 ins_match;
    logic                 rem_match;
    logic                 match;

    // The chain carries "the edit point lies at or before this slot" towards the tail.
    always_comb
    begin
        ins_match = ctrl.prio_mode ? ((occupied && (new_prio <= prio_reg)) || at_tail)
                                   : (ctrl.lifo_mode ? is_head : at_tail);
        rem_match = occupied && (task_reg == new_task);
        match     = 1'b0;
        task_next = task_reg;
        prio_next = prio_reg;
        unique case (ctrl.op)
            CELL_HOLD:
            begin
                match = 1'b0;
            end
            CELL_INSERT:
            begin
                match = ins_match;
                if (chain_in)
                begin
                    task_next = left_task;
                    prio_next = left_prio;
                end
                else if (ins_match)
                begin
                    task_next = new_task;
                    prio_next = new_prio;
                end
            end
            CELL_REMOVE:
            begin
                match = rem_match;
                if (chain_in || rem_match)
                begin
                    task_next = right_task;
                    prio_next = right_prio;
                end
            end
            CELL_SHIFT:
            begin
                match     = 1'b0;
                task_next = right_task;
                prio_next = right_prio;
            end
            default:
            begin
                match = 1'b0;
            end
        endcase
        chain_out = chain_in | match;
    end

    always_ff @(posedge clk)
    begin
        task_reg <= task_next;
        prio_reg <= prio_next;
    end

    assign task_id = task_reg;
    assign prio    = prio_reg;

endmodule

/* sv/task_wait_queue_ordering.sv */
// Wait queue of blocked task ids kept in order in a row of shifting cells.
// Insert and remove: the input transaction is latched in S_IDLE and the result register
// loads in S_EXEC once the output slot is free; no new command is taken until then.
// Flush of N entries: one released entry per cycle out of the head while the output slot is free.
// A result left waiting in the output register holds the next edit back for as long.
// Reset clears the state machine, the fill count, the mode and the output valid;
// the cell contents stay undefined and are never read beyond the fill count.
module task_wait_queue_ordering #(
    parameter int DEPTH     = 16,
    parameter int PRIO_BITS = 16
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_wr_en,
    input  logic [twqo_pkg::MODE_BITS-1:0]    cfg_wr_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [twqo_pkg::CMD_BITS-1:0]     cmd,
    input  logic [twqo_pkg::TASK_BITS-1:0]    task_id,
    input  logic [twqo_pkg::PRIO_IN_BITS-1:0] priority_req,
    input  logic [twqo_pkg::CODE_BITS-1:0]    err_code,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [twqo_pkg::TASK_BITS-1:0]    out_task,
    output logic [twqo_pkg::CODE_BITS-1:0]    out_code,
    output logic [twqo_pkg::STATUS_BITS-1:0]  status,
    output logic                              last
);
    import twqo_pkg::*;

    localparam int FILL_BITS = $clog2(DEPTH + 1);

    // Controller registers.
    state_t               state_reg, state_next;
    logic [FILL_BITS-1:0] fill_reg, fill_next;
    logic [MODE_BITS-1:0] mode_reg;

    // The accepted transaction is held here while the cells work on it.
    logic [CMD_BITS-1:0]  cmd_reg;
    logic [TASK_BITS-1:0] task_reg;
    logic [PRIO_BITS-1:0] prio_reg;
    logic [CODE_BITS-1:0] code_reg;

    // Output register, which lets a new transaction in while a result waits.
    logic                   out_valid_reg;
    logic [TASK_BITS-1:0]   out_task_reg;
    logic [CODE_BITS-1:0]   out_code_reg;
    logic [STATUS_BITS-1:0] out_status_reg;
    logic                   out_last_reg;

    logic                   load_out;
    logic [TASK_BITS-1:0]   res_task;
    logic [CODE_BITS-1:0]   res_code;
    logic [STATUS_BITS-1:0] res_status;
    logic                   res_last;
    logic                   out_free;
    logic                   in_fire;

    cell_ctrl_t             cell_ctrl;
    logic [TASK_BITS-1:0]   cell_task [DEPTH];
    logic [PRIO_BITS-1:0]   cell_prio [DEPTH];
    logic [DEPTH:0]         chain;

    assign in_ready = (state_reg == S_IDLE);
    assign in_fire  = in_valid && in_ready;
    assign out_free = !out_valid_reg || out_ready;

    // The edit chain starts clear at the head; whatever leaves the tail cell
    // tells whether a remove found its task.
    assign chain[0] = 1'b0;

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [TASK_BITS-1:0] left_task;
        logic [PRIO_BITS-1:0] left_prio;
        logic [TASK_BITS-1:0] right_task;
        logic [PRIO_BITS-1:0] right_prio;

        if (i == 0)
        begin : g_head
            assign left_task = task_reg;
            assign left_prio = prio_reg;
        end
        else
        begin : g_body
            assign left_task = cell_task[i-1];
            assign left_prio = cell_prio[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_tail
            assign right_task = cell_task[i];
            assign right_prio = cell_prio[i];
        end
        else
        begin : g_inner
            assign right_task = cell_task[i+1];
            assign right_prio = cell_prio[i+1];
        end

        twqo_cell #(
            .PRIO_BITS (PRIO_BITS)
        ) u_cell (
            .clk        (clk),
            .ctrl       (cell_ctrl),
            .occupied   (FILL_BITS'(i) < fill_reg),
            .at_tail    (FILL_BITS'(i) == fill_reg),
            .is_head    (i == 0),
            .new_task   (task_reg),
            .new_prio   (prio_reg),
            .left_task  (left_task),
            .left_prio  (left_prio),
            .right_task (right_task),
            .right_prio (right_prio),
            .chain_in   (chain[i]),
            .chain_out  (chain[i+1]),
            .task_id    (cell_task[i]),
            .prio       (cell_prio[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            fill_reg      <= '0;
            mode_reg      <= MODE_PRIO;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            if (cfg_wr_en)
            begin
                mode_reg <= cfg_wr_data;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg  <= cmd;
            task_reg <= task_id;
            prio_reg <= priority_req[PRIO_BITS-1:0];
            code_reg <= err_code;
        end
        if (load_out)
        begin
            out_task_reg   <= res_task;
            out_code_reg   <= res_code;
            out_status_reg <= res_status;
            out_last_reg   <= res_last;
        end
    end

    // Command sequencing. Every edit of the cells happens in the same cycle
    // as its result enters the output register, so an edit waits for a free
    // output slot.
    always_comb
    begin
        state_next          = state_reg;
        fill_next           = fill_reg;
        cell_ctrl.op        = CELL_HOLD;
        cell_ctrl.prio_mode = (mode_reg == MODE_PRIO);
        cell_ctrl.lifo_mode = (mode_reg == MODE_LIFO);
        load_out            = 1'b0;
        res_task            = task_reg;
        res_code            = '0;
        res_status          = STAT_OK;
        res_last            = 1'b1;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (cmd_reg)
                    CMD_INSERT:
                    begin
                        if (out_free)
                        begin
                            load_out   = 1'b1;
                            state_next = S_IDLE;
                            if (mode_reg == MODE_BAD)
                            begin
                                res_status = STAT_BAD_MODE;
                            end
                            else if (fill_reg == FILL_BITS'(DEPTH))
                            begin
                                res_status = STAT_FULL;
                            end
                            else
                            begin
                                cell_ctrl.op = CELL_INSERT;
                                fill_next    = fill_reg + 1'b1;
                            end
                        end
                    end
                    CMD_REMOVE:
                    begin
                        if (out_free)
                        begin
                            load_out     = 1'b1;
                            state_next   = S_IDLE;
                            cell_ctrl.op = CELL_REMOVE;
                            if (chain[DEPTH])
                            begin
                                fill_next = fill_reg - 1'b1;
                                res_code  = code_reg;
                            end
                            else
                            begin
                                res_status = STAT_NOT_FOUND;
                            end
                        end
                    end
                    CMD_FLUSH:
                    begin
                        if (fill_reg == '0)
                        begin
                            if (out_free)
                            begin
                                load_out   = 1'b1;
                                state_next = S_IDLE;
                                res_task   = '0;
                                res_status = STAT_EMPTY;
                            end
                        end
                        else
                        begin
                            state_next = S_FLUSH;
                        end
                    end
                    default:
                    begin
                        // The unused command is dropped without a result.
                        state_next = S_IDLE;
                    end
                endcase
            end
            S_FLUSH:
            begin
                // The head cell is released and the whole row moves one
                // slot towards the head.
                if (out_free)
                begin
                    load_out     = 1'b1;
                    cell_ctrl.op = CELL_SHIFT;
                    res_task     = cell_task[0];
                    res_code     = code_reg;
                    res_last     = (fill_reg == FILL_BITS'(1));
                    fill_next    = fill_reg - 1'b1;
                    if (fill_reg == FILL_BITS'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign out_task  = out_task_reg;
    assign out_code  = out_code_reg;
    assign status    = out_status_reg;
    assign last      = out_last_reg;

endmodule

/* tb/sv/tb_task_wait_queue_ordering.sv */
// Self-checking testbench for the task wait queue ordering block.
// Sends insert, remove and flush transactions, predicts every answer from its own copy
// of the wait queue and checks each result in order. Depends on twqo_pkg and the RTL.
module tb_task_wait_queue_ordering;
    timeunit 1ns;
    timeprecision 1ps;

    import twqo_pkg::*;

    // Size of the queue under test; the predictor uses the same figure.
    localparam int QDEPTH = 16;
    localparam int PRIO_W = 16;

    // The fourth command code has no name in the package and is ignored by the block.
    localparam logic [CMD_BITS-1:0] CMD_UNUSED = 2'd3;

    // Cycles without any transaction before the run is declared hung. The longest
    // deliberate hold-off on the result side is LONG_HOLD, so this leaves ample margin.
    localparam int STALL_LIMIT   = 3000;
    localparam int LONG_HOLD     = 400;
    // Pause after the last expected result before touching the mode register, since
    // an ignored command may still be passing through the pipeline.
    localparam int SETTLE_CYCLES = 20;

    // One waiting task as the predictor holds it, head of the queue at index 0.
    typedef struct {
        logic [TASK_BITS-1:0]    tid;
        logic [PRIO_IN_BITS-1:0] prio;
    } waiter_t;

    // One result as the block should present it.
    typedef struct {
        logic [TASK_BITS-1:0]   tid;
        logic [CODE_BITS-1:0]   code;
        logic [STATUS_BITS-1:0] stat;
        logic                   fin;
    } answer_t;

    logic                    clk = 1'b0;
    logic                    rst_n;
    logic                    cfg_wr_en;
    logic [MODE_BITS-1:0]    cfg_wr_data;
    logic                    in_valid;
    logic                    in_ready;
    logic [CMD_BITS-1:0]     cmd;
    logic [TASK_BITS-1:0]    task_id;
    logic [PRIO_IN_BITS-1:0] priority_req;
    logic [CODE_BITS-1:0]    err_code;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [TASK_BITS-1:0]    out_task;
    logic [CODE_BITS-1:0]    out_code;
    logic [STATUS_BITS-1:0]  status;
    logic                    last;

    // Predictor state: the order mode as last written, and the waiting tasks.
    logic [MODE_BITS-1:0] model_mode;
    waiter_t              wait_list[$];
    // Results still owed by the block, oldest first.
    answer_t              expected_answers[$];
    answer_t              want;

    int error_count = 0;
    int idle_cycles = 0;
    int send_idle_pct;
    int recv_idle_pct;

    // The long hold-off on the result side is requested by toggling hold_req; the
    // receiving process notices the change and counts the stretch itself.
    logic hold_req;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    always #5 clk = ~clk;

    task_wait_queue_ordering #(
        .DEPTH     (QDEPTH),
        .PRIO_BITS (PRIO_W)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .cmd          (cmd),
        .task_id      (task_id),
        .priority_req (priority_req),
        .err_code     (err_code),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_task     (out_task),
        .out_code     (out_code),
        .status       (status),
        .last         (last)
    );

    function automatic void push_answer(input logic [TASK_BITS-1:0] tid,
                                        input logic [CODE_BITS-1:0] code,
                                        input logic [STATUS_BITS-1:0] stat,
                                        input logic fin);
        answer_t a;
        a.tid  = tid;
        a.code = code;
        a.stat = stat;
        a.fin  = fin;
        expected_answers.push_back(a);
    endfunction

    // Applies one accepted transaction to the predicted queue and records the
    // results it must cause.
    function automatic void predict_wait_queue(input logic [CMD_BITS-1:0] c,
                                               input logic [TASK_BITS-1:0] tid,
                                               input logic [PRIO_IN_BITS-1:0] prio,
                                               input logic [CODE_BITS-1:0] code);
        int      pos;
        int      n;
        waiter_t w;
        w.tid  = tid;
        w.prio = prio;
        n = wait_list.size();
        case (c)
            CMD_INSERT:
            begin
                // An unknown mode is reported even when the queue is also full.
                if (model_mode == MODE_BAD)
                    push_answer(tid, '0, STAT_BAD_MODE, 1'b1);
                else if (n >= QDEPTH)
                    push_answer(tid, '0, STAT_FULL, 1'b1);
                else
                begin
                    if (model_mode == MODE_FIFO)
                        wait_list.push_back(w);
                    else if (model_mode == MODE_LIFO)
                        wait_list.push_front(w);
                    else
                    begin
                        // The new task goes in front of the first entry that is no
                        // more urgent than itself, so equal priorities end up newest first.
                        pos = n;
                        for (int i = n - 1; i >= 0; i--)
                            if (prio <= wait_list[i].prio)
                                pos = i;
                        wait_list.insert(pos, w);
                    end
                    push_answer(tid, '0, STAT_OK, 1'b1);
                end
            end
            CMD_REMOVE:
            begin
                // Only the entry nearest the head is taken when an id is queued twice.
                pos = -1;
                for (int i = n - 1; i >= 0; i--)
                    if (wait_list[i].tid == tid)
                        pos = i;
                if (pos >= 0)
                begin
                    wait_list.delete(pos);
                    push_answer(tid, code, STAT_OK, 1'b1);
                end
                else
                    push_answer(tid, '0, STAT_NOT_FOUND, 1'b1);
            end
            CMD_FLUSH:
            begin
                if (n == 0)
                    push_answer('0, '0, STAT_EMPTY, 1'b1);
                else
                begin
                    for (int i = 0; i < n; i++)
                        push_answer(wait_list[i].tid, code, STAT_OK, i == n - 1);
                    wait_list.delete();
                end
            end
            default:
            begin
                // The unused command is dropped without a result.
            end
        endcase
    endfunction

    // Offers one transaction and returns at the edge where it is accepted. Valid is
    // left high so that a following call can present its item without a gap; the
    // sender only drops valid when it decides to idle or when a test pauses.
    task automatic send_item(input logic [CMD_BITS-1:0] c,
                             input logic [TASK_BITS-1:0] tid,
                             input logic [PRIO_IN_BITS-1:0] prio,
                             input logic [CODE_BITS-1:0] code);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        cmd          <= c;
        task_id      <= tid;
        priority_req <= prio;
        err_code     <= code;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        predict_wait_queue(c, tid, prio, code);
    endtask

    // Stops offering and waits until every predicted result has been seen, then
    // lets the pipeline settle so that the mode may be changed safely.
    task automatic wait_queue_settled();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_answers.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_order_mode(input logic [MODE_BITS-1:0] m);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= m;
        @(posedge clk);
        cfg_wr_en  <= 1'b0;
        model_mode = m;
    endtask

    // Straight after reset the queue is empty: a flush reports an empty queue, a
    // remove finds nothing, and the unused command yields no result at all.
    task automatic test_empty_queue();
        send_item(CMD_FLUSH, 6'd0, 16'd0, 4'd9);
        send_item(CMD_REMOVE, 6'd63, 16'hFFFF, 4'd15);
        send_item(CMD_UNUSED, 6'd21, 16'h5A5A, 4'd6);
        wait_queue_settled();
    endtask

    // Priority ordering relies on the reset value of the mode. Priority extremes,
    // a tie that must land in front of the older entry, remove hit and miss.
    task automatic test_priority_insert();
        send_item(CMD_INSERT, 6'd5, 16'd100, 4'd15);
        send_item(CMD_INSERT, 6'd63, 16'hFFFF, 4'd0);
        send_item(CMD_INSERT, 6'd0, 16'd0, 4'd3);
        send_item(CMD_INSERT, 6'd7, 16'd100, 4'd0);
        send_item(CMD_REMOVE, 6'd63, 16'd0, 4'd15);
        send_item(CMD_REMOVE, 6'd42, 16'd0, 4'd4);
        send_item(CMD_FLUSH, 6'd33, 16'd0, 4'd0);
        wait_queue_settled();
    endtask

    // Tail appends in FIFO mode, head inserts in LIFO mode, and a duplicated id
    // where the remove must take the copy nearest the head.
    task automatic test_fifo_lifo();
        write_order_mode(MODE_FIFO);
        send_item(CMD_INSERT, 6'd1, 16'd9, 4'd0);
        send_item(CMD_INSERT, 6'd2, 16'd1, 4'd0);
        send_item(CMD_INSERT, 6'd1, 16'd0, 4'd0);
        wait_queue_settled();
        write_order_mode(MODE_LIFO);
        send_item(CMD_INSERT, 6'd3, 16'd50, 4'd0);
        send_item(CMD_REMOVE, 6'd1, 16'd0, 4'd10);
        send_item(CMD_FLUSH, 6'd0, 16'd0, 4'd15);
        wait_queue_settled();
    endtask

    // The unknown mode refuses inserts and leaves the queue empty.
    task automatic test_bad_mode();
        write_order_mode(MODE_BAD);
        send_item(CMD_INSERT, 6'd10, 16'd10, 4'd0);
        send_item(CMD_FLUSH, 6'd0, 16'd0, 4'd5);
        wait_queue_settled();
    endtask

    // The result side holds off for a long stretch while inserts keep coming, so
    // the block backs up and must stall its input. The queue also runs full, and
    // then an insert in the unknown mode must be refused for the mode, not the fill.
    task automatic test_backpressure_full();
        write_order_mode(MODE_FIFO);
        send_item(CMD_FLUSH, 6'd0, 16'd0, 4'd0);
        hold_req <= ~hold_req;
        for (int k = 0; k < QDEPTH + 4; k++)
            send_item(CMD_INSERT, 6'($urandom), 16'($urandom), 4'($urandom));
        wait_queue_settled();
        write_order_mode(MODE_BAD);
        send_item(CMD_INSERT, 6'($urandom), 16'($urandom), 4'($urandom));
        send_item(CMD_FLUSH, 6'($urandom), 16'($urandom), 4'($urandom));
        wait_queue_settled();
    endtask

    // Random traffic shaped to keep the queue busy: inserts outnumber removals so
    // that the queue reaches full now and then, most removals name a task that is
    // actually waiting, and flushes are rare enough to let long queues build up.
    // Priorities are often drawn from a narrow range to force ties.
    task automatic run_random_traffic(input int count, input int flush_pct);
        logic [CMD_BITS-1:0]     c;
        logic [TASK_BITS-1:0]    tid;
        logic [PRIO_IN_BITS-1:0] prio;
        logic [CODE_BITS-1:0]    code;
        int                      r;
        for (int k = 0; k < count; k++)
        begin
            r    = $urandom_range(99);
            code = 4'($urandom);
            prio = $urandom_range(1) ? 16'($urandom) : 16'($urandom_range(7));
            tid  = $urandom_range(1) ? 6'($urandom) : 6'($urandom_range(7));
            if (r < 2)
                c = CMD_UNUSED;
            else if (r < 2 + flush_pct)
                c = CMD_FLUSH;
            else if (r < 37 + flush_pct)
            begin
                c = CMD_REMOVE;
                if (wait_list.size() != 0 && $urandom_range(99) < 75)
                    tid = wait_list[$urandom_range(wait_list.size() - 1)].tid;
            end
            else
                c = CMD_INSERT;
            send_item(c, tid, prio, code);
        end
    endtask

    // One pass through every order mode under a given idling pattern. The queue
    // contents carry over from one mode into the next.
    task automatic test_random_orders(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        write_order_mode(MODE_PRIO);
        run_random_traffic(60, 3);
        wait_queue_settled();
        write_order_mode(MODE_FIFO);
        run_random_traffic(40, 4);
        wait_queue_settled();
        write_order_mode(MODE_LIFO);
        run_random_traffic(40, 4);
        wait_queue_settled();
        write_order_mode(MODE_BAD);
        run_random_traffic(15, 6);
        wait_queue_settled();
    endtask

    // Result side: the ready decision is taken at each edge, and a transaction is
    // checked against the oldest prediction using the values held before the edge.
    always @(posedge clk)
    begin
        if (out_valid && out_ready)
        begin
            if (expected_answers.size() == 0)
            begin
                $error("unexpected result: out_task %0d out_code %0d status %0d last %0b",
                       out_task, out_code, status, last);
                error_count++;
            end
            else
            begin
                want = expected_answers.pop_front();
                if (out_task !== want.tid)
                begin
                    $error("out_task: expected %0d, got %0d", want.tid, out_task);
                    error_count++;
                end
                if (out_code !== want.code)
                begin
                    $error("out_code: expected %0d, got %0d", want.code, out_code);
                    error_count++;
                end
                if (status !== want.stat)
                begin
                    $error("status: expected %0d, got %0d", want.stat, status);
                    error_count++;
                end
                if (last !== want.fin)
                begin
                    $error("last: expected %0b, got %0b", want.fin, last);
                    error_count++;
                end
            end
        end
        if (hold_req != hold_seen)
        begin
            hold_seen = hold_req;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    // Watchdog: any transaction on either channel counts as progress.
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = MODE_PRIO;
        in_valid     = 1'b0;
        cmd          = CMD_INSERT;
        task_id      = '0;
        priority_req = '0;
        err_code     = '0;
        hold_req     = 1'b0;
        model_mode   = MODE_PRIO;
        // Directed tests run with a slow receiver and an eager sender.
        send_idle_pct = 8;
        recv_idle_pct = 76;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_queue();
        test_priority_insert();
        test_fifo_lifo();
        test_bad_mode();
        test_backpressure_full();
        test_random_orders(8, 76);
        test_random_orders(76, 8);
        test_random_orders(0, 0);

        if (error_count == 0 && expected_answers.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
